// ===== rtl/core/oafsm_pkg.sv =====
// Package for the obstacle-avoidance controller.
// Holds operation codes, configuration indexes, controller state codes, speed and indicator constants.
// No dependencies.
`default_nettype none

package oafsm_pkg;

    // Signed motor speed command in percent.
    typedef logic signed [5:0] speed_t;

    // Item operation codes.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SENSOR = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;
    localparam logic [1:0] OP_HALT   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NEAR_FORTY  = 2'd0;
    localparam logic [1:0] CFG_NEAR_THIRTY = 2'd1;
    localparam logic [1:0] CFG_START_WAIT  = 2'd2;
    localparam logic [1:0] CFG_QUICK_TURN  = 2'd3;

    // Controller states: even codes start a behavior, odd codes run it.
    localparam logic [3:0] MODE_WAIT_START    = 4'd0;
    localparam logic [3:0] MODE_WAIT_RUN      = 4'd1;
    localparam logic [3:0] MODE_FWD_START     = 4'd2;
    localparam logic [3:0] MODE_FWD_RUN       = 4'd3;
    localparam logic [3:0] MODE_LEFT_START    = 4'd4;
    localparam logic [3:0] MODE_LEFT_RUN      = 4'd5;
    localparam logic [3:0] MODE_RIGHT_START   = 4'd6;
    localparam logic [3:0] MODE_RIGHT_RUN     = 4'd7;
    localparam logic [3:0] MODE_SPIN_START    = 4'd8;
    localparam logic [3:0] MODE_SPIN_RUN      = 4'd9;
    localparam logic [3:0] MODE_QLEFT_START   = 4'd10;
    localparam logic [3:0] MODE_QLEFT_RUN     = 4'd11;
    localparam logic [3:0] MODE_QRIGHT_START  = 4'd12;
    localparam logic [3:0] MODE_QRIGHT_RUN    = 4'd13;
    localparam logic [3:0] MODE_SLOW_START    = 4'd14;
    localparam logic [3:0] MODE_SLOW_RUN      = 4'd15;

    // Speed commands.
    localparam speed_t SPEED_ZERO     = 6'sd0;
    localparam speed_t SPEED_FAST     = 6'sd30;
    localparam speed_t SPEED_TURN     = 6'sd10;
    localparam speed_t SPEED_TURN_REV = -6'sd10;
    localparam speed_t SPEED_SLOW     = 6'sd15;
    localparam speed_t SPEED_SLOW_REV = -6'sd15;

    // Indicator patterns: bit0 white, bit1 blue, bit2 orange, bit3 red, bit4 green.
    localparam logic [4:0] LED_ALL        = 5'h1F;
    localparam logic [4:0] LED_NONE       = 5'h00;
    localparam logic [4:0] LED_OBST_RIGHT = 5'h18;
    localparam logic [4:0] LED_OBST_LEFT  = 5'h03;
    localparam logic [4:0] LED_QLEFT      = 5'h10;
    localparam logic [4:0] LED_QRIGHT     = 5'h01;
    localparam logic [4:0] LED_BOTH       = 5'h11;

endpackage

`default_nettype wire

// ===== rtl/core/obstacle_avoidance_fsm_top.sv =====
// Obstacle-avoidance controller, top level and only module.
// Depends on oafsm_pkg for codes and constants.
//
// Usage: items arrive on the in_valid/in_ready channel, one transfer per item,
// carrying an operation code and five range counts (used only by a sensor
// update). Every item gives exactly one result on the out_valid/out_ready
// channel: the controller state after the item, both motor speeds, a flag
// that says whether this item issued new speed commands, and the five LEDs.
// All work for an item is done in the cycle it is accepted, so the result is
// presented in the cycle after the transfer. The controller state registers
// double as the result register; a new item is accepted in the same cycle
// the waiting result is taken, giving a sustained rate of one item per clock
// while the receiver takes results, set by the single state update per item.
// When the receiver stalls, the result holds and in_ready falls until it is
// taken. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
// next edge; the user must make them only while the block is idle, as the
// block itself does not enforce it. Reset puts the controller in the wait
// start state with the time counter and range counts at zero, speeds at zero,
// all LEDs lit, thresholds at their defaults and no result pending.
`default_nettype none

module obstacle_avoidance_fsm_top
    import oafsm_pkg::*;
#(
    parameter int COUNT_BITS = 12,
    parameter int TICK_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            op,
    input  wire logic [COUNT_BITS-1:0] far_left_count,
    input  wire logic [COUNT_BITS-1:0] left_count,
    input  wire logic [COUNT_BITS-1:0] centre_count,
    input  wire logic [COUNT_BITS-1:0] right_count,
    input  wire logic [COUNT_BITS-1:0] far_right_count,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [3:0]                 mode_now,
    output logic signed [5:0]          right_speed,
    output logic signed [5:0]          left_speed,
    output logic                       speed_set,
    output logic [4:0]                 indicator_bits
);

    // Width used to compare the tick counter against 16-bit thresholds.
    localparam int CMP_BITS = (TICK_BITS > 16) ? TICK_BITS : 16;

    // Configuration registers.
    logic [COUNT_BITS-1:0] near_forty_reg;
    logic [COUNT_BITS-1:0] near_thirty_reg;
    logic [15:0]           start_wait_reg;
    logic [15:0]           quick_turn_reg;

    // Controller state. These registers are also what the result shows.
    logic [3:0]            mode_reg,      mode_next;
    logic [TICK_BITS-1:0]  elapsed_reg,   elapsed_next;
    logic [COUNT_BITS-1:0] far_left_reg,  left_reg, centre_reg, right_reg, far_right_reg;
    logic [4:0]            led_reg,       led_next;
    speed_t                right_spd_reg, right_spd_next;
    speed_t                left_spd_reg,  left_spd_next;
    logic                  speed_set_reg, speed_set_next;
    logic                  out_valid_reg;

    logic                  accept;
    logic                  wait_done;
    logic                  quick_done;
    logic                  obst_r40;
    logic                  obst_l40;
    logic                  obst_c40;
    logic                  centre_far30;
    logic [3:0]            class_mode;
    logic [4:0]            class_leds;
    logic                  class_keep;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign wait_done  = CMP_BITS'(elapsed_reg) > CMP_BITS'(start_wait_reg);
    assign quick_done = CMP_BITS'(elapsed_reg) > CMP_BITS'(quick_turn_reg);

    // Obstacle classification from the latched range counts. A larger count
    // means a closer obstacle, so "nearer than" tests are at-or-above tests.
    assign obst_r40     = right_reg  >= near_forty_reg;
    assign obst_l40     = left_reg   >= near_forty_reg;
    assign obst_c40     = centre_reg >= near_forty_reg;
    assign centre_far30 = centre_reg <  near_thirty_reg;

    always_comb
    begin
        priority if (obst_r40 && centre_far30 && !obst_l40)
        begin
            class_mode = MODE_LEFT_START;
            class_leds = LED_OBST_RIGHT;
        end
        else if (!obst_r40 && centre_far30 && obst_l40)
        begin
            class_mode = MODE_RIGHT_START;
            class_leds = LED_OBST_LEFT;
        end
        else if (obst_c40)
        begin
            // Front obstacle: turn away from the closer outer side; with equal outer
            // counts, or the lower one not under the thirty threshold, the robot spins in place.
            priority if (far_left_reg < near_thirty_reg && far_left_reg < far_right_reg)
            begin
                class_mode = MODE_QLEFT_START;
                class_leds = LED_QLEFT;
            end
            else if (far_right_reg < near_thirty_reg && far_right_reg < far_left_reg)
            begin
                class_mode = MODE_QRIGHT_START;
                class_leds = LED_QRIGHT;
            end
            else
            begin
                class_mode = MODE_SPIN_START;
                class_leds = LED_ALL;
            end
        end
        else if (obst_r40 && obst_l40)
        begin
            class_mode = MODE_SLOW_START;
            class_leds = LED_BOTH;
        end
        else
        begin
            class_mode = MODE_FWD_START;
            class_leds = LED_NONE;
        end
    end

    // Reclassifying to the start state of the behavior already running
    // leaves both the state and the LEDs alone.
    assign class_keep = (mode_reg != MODE_WAIT_START) && (class_mode == mode_reg - 4'd1);

    always_comb
    begin
        mode_next      = mode_reg;
        elapsed_next   = elapsed_reg;
        led_next       = led_reg;
        right_spd_next = right_spd_reg;
        left_spd_next  = left_spd_reg;
        speed_set_next = 1'b0;

        unique case (op)
            OP_TICK:
            begin
                if (elapsed_reg != {TICK_BITS{1'b1}})
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            OP_SENSOR:
            begin
                // Range counts are latched in the register block below.
            end
            OP_STEP:
            begin
                unique case (mode_reg)
                    MODE_WAIT_START:
                    begin
                        // The counter is cleared here, so the exit test
                        // cannot pass on this same step.
                        elapsed_next   = '0;
                        right_spd_next = SPEED_ZERO;
                        left_spd_next  = SPEED_ZERO;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_WAIT_RUN;
                    end
                    MODE_WAIT_RUN:
                    begin
                        if (wait_done)
                        begin
                            mode_next = MODE_FWD_START;
                        end
                    end
                    MODE_FWD_START:
                    begin
                        right_spd_next = SPEED_FAST;
                        left_spd_next  = SPEED_FAST;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_FWD_RUN;
                    end
                    MODE_LEFT_START:
                    begin
                        right_spd_next = SPEED_TURN;
                        left_spd_next  = SPEED_ZERO;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_LEFT_RUN;
                    end
                    MODE_RIGHT_START:
                    begin
                        right_spd_next = SPEED_TURN;
                        left_spd_next  = SPEED_TURN;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_RIGHT_RUN;
                    end
                    MODE_SPIN_START:
                    begin
                        right_spd_next = SPEED_TURN;
                        left_spd_next  = SPEED_TURN_REV;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_SPIN_RUN;
                    end
                    MODE_QLEFT_START:
                    begin
                        right_spd_next = SPEED_TURN;
                        left_spd_next  = SPEED_TURN_REV;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_QLEFT_RUN;
                        elapsed_next   = '0;
                    end
                    MODE_QRIGHT_START:
                    begin
                        right_spd_next = SPEED_TURN_REV;
                        left_spd_next  = SPEED_TURN;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_QRIGHT_RUN;
                        elapsed_next   = '0;
                    end
                    MODE_SLOW_START:
                    begin
                        right_spd_next = SPEED_SLOW_REV;
                        left_spd_next  = SPEED_SLOW;
                        speed_set_next = 1'b1;
                        mode_next      = MODE_SLOW_RUN;
                    end
                    MODE_QLEFT_RUN,
                    MODE_QRIGHT_RUN:
                    begin
                        if (quick_done && !class_keep)
                        begin
                            mode_next = class_mode;
                            led_next  = class_leds;
                        end
                    end
                    default:
                    begin
                        // Forward, turn, spin and slow running states.
                        if (!class_keep)
                        begin
                            mode_next = class_mode;
                            led_next  = class_leds;
                        end
                    end
                endcase
            end
            OP_HALT:
            begin
                mode_next = MODE_WAIT_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_forty_reg  <= COUNT_BITS'(938);
            near_thirty_reg <= COUNT_BITS'(1206);
            start_wait_reg  <= 16'd1000;
            quick_turn_reg  <= 16'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEAR_FORTY:  near_forty_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_NEAR_THIRTY: near_thirty_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_START_WAIT:  start_wait_reg  <= cfg_data;
                CFG_QUICK_TURN:  quick_turn_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT_START;
            elapsed_reg   <= '0;
            far_left_reg  <= '0;
            left_reg      <= '0;
            centre_reg    <= '0;
            right_reg     <= '0;
            far_right_reg <= '0;
            led_reg       <= LED_ALL;
            right_spd_reg <= SPEED_ZERO;
            left_spd_reg  <= SPEED_ZERO;
            speed_set_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                elapsed_reg   <= elapsed_next;
                led_reg       <= led_next;
                right_spd_reg <= right_spd_next;
                left_spd_reg  <= left_spd_next;
                speed_set_reg <= speed_set_next;
                if (op == OP_SENSOR)
                begin
                    far_left_reg  <= far_left_count;
                    left_reg      <= left_count;
                    centre_reg    <= centre_count;
                    right_reg     <= right_count;
                    far_right_reg <= far_right_count;
                end
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode_now       = mode_reg;
    assign right_speed    = right_spd_reg;
    assign left_speed     = left_spd_reg;
    assign speed_set      = speed_set_reg;
    assign indicator_bits = led_reg;

`ifndef NO_ASSERTIONS
    // A halt always lands in the wait start state without a speed command.
    a_halt_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_HALT |=> mode_now == MODE_WAIT_START && !speed_set)
        else $error("halt did not force the wait start state");

    // Every speed command leaves the controller in a running (odd) state.
    a_cmd_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speed_set |-> mode_now[0])
        else $error("speed command left a start state");

    // Ticks and sensor updates never issue speed commands.
    a_no_cmd_non_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_TICK || op == OP_SENSOR) |=> !speed_set)
        else $error("non-step item issued a speed command");

    // With no result pending the block is always ready for an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty result register");
`endif

endmodule

`default_nettype wire
